// File: rtl/core/rpt_pkg.sv
// Shared types and codes for the retransmit pending tracker.
// Used by retransmit_pending_tracker_core; no dependencies.
`default_nettype none

package rpt_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_SENT         = 3'd0,
    KIND_RETRANSMIT   = 3'd1,
    KIND_DROP_FULL    = 3'd2,
    KIND_DROP_RETRIES = 3'd3,
    KIND_ACK_MATCHED  = 3'd4,
    KIND_ACK_IGNORED  = 3'd5,
    KIND_TICK_DONE    = 3'd6
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PENDING_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_RETRY_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_RETRY_INTERVAL = 2'd2;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // One pending-message entry as kept in the slot memory.
  typedef struct packed {
    logic [31:0] seq;
    logic [3:0]  peer;
    logic [15:0] tag;
    logic [31:0] deadline;
    logic [7:0]  attempts;
  } slot_t;

endpackage

`default_nettype wire

// File: rtl/core/rpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; used for the slot store of the tracker.
`default_nettype none

module rpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/retransmit_pending_tracker_core.sv
// Top level of the retransmit pending tracker: send, ack and tick handling.
// Depends on rpt_pkg (types, codes) and rpt_ram (slot store).
`default_nettype none

// Usage
// An item (send, ack or tick) is taken when start is high and busy is low.
// Results appear on the out_ ports for one cycle each with out_valid high;
// out_last marks the final result of an item. The receiver cannot stall.
// Configuration writes use cfg_valid/cfg_ready (always ready); index 0 is
// the pending limit, 1 the retry limit, 2 the retry interval. Write only
// while busy is low and no result is still due.
// Timing
// A send completes in the accept cycle: its single result shows the next
// cycle and busy stays low, so sends can follow back to back.
// An ack scans the slot memory one entry per cycle through its one read
// port, ending at the first match or after the last slot.
// A tick reads every slot once, writes back retransmitted entries behind
// the read stream and ends with a done result.
// The scan rate is set by the single read port of the slot memory.
// Reset
// rst_n frees all slots, clears the pending count and the tick counter, sets the
// next sequence number to one and loads the default configuration.

module retransmit_pending_tracker_core #(
  parameter int SLOTS = 16,
  parameter int PEERS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Item channel.
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [3:0]  in_peer_index,
  input  wire logic [15:0] in_payload_tag,
  input  wire logic [31:0] in_ack_sequence,
  // Result channel.
  output logic             out_valid,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_sequence_res,
  output logic [3:0]       out_peer,
  output logic [15:0]      out_tag,
  output logic [7:0]       out_attempt_count,
  output logic             out_last,
  // Configuration channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(SLOTS + 1);
  localparam int SW = $bits(rpt_pkg::slot_t);
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

  // Configuration registers.
  logic [4:0]  pending_limit_r;
  logic [7:0]  retry_limit_r;
  logic [15:0] retry_interval_r;

  // Control and bookkeeping state.
  rpt_pkg::state_t state_r, state_nxt;
  rpt_pkg::op_t    op_r, op_nxt;
  logic [3:0]      peer_r, peer_nxt;
  logic [31:0]     ack_seq_r, ack_seq_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            iss_done_r, iss_done_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [PW-1:0]   total_r, total_nxt;
  logic [31:0]     next_seq_r, next_seq_nxt;
  logic [31:0]     tick_now_r, tick_now_nxt;

  // Result registers.
  logic            o_valid_r, o_valid_nxt;
  rpt_pkg::kind_t  o_kind_r, o_kind_nxt;
  logic [31:0]     o_seq_r, o_seq_nxt;
  logic [3:0]      o_peer_r, o_peer_nxt;
  logic [15:0]     o_tag_r, o_tag_nxt;
  logic [7:0]      o_att_r, o_att_nxt;
  logic            o_last_r, o_last_nxt;

  // Slot memory ports.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  rpt_pkg::slot_t  ram_wdata;
  logic            ram_re;
  rpt_pkg::slot_t  rd_slot;
  logic [SW-1:0]   ram_rdata;

  // Send-path helpers.
  logic            free_found;
  logic [AW-1:0]   free_idx;
  logic [31:0]     eff_limit;
  logic            send_ok;
  logic [31:0]     new_deadline;

  // Scan-path helpers.
  logic            rd_valid;
  logic [31:0]     dl_diff;
  logic            expired;
  logic            ack_hit;

  rpt_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  assign rd_slot = rpt_pkg::slot_t'(ram_rdata);

  // Configuration writes; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_limit_r  <= 5'd16;
      retry_limit_r    <= 8'd3;
      retry_interval_r <= 16'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rpt_pkg::CFG_PENDING_LIMIT:  pending_limit_r  <= cfg_data[4:0];
        rpt_pkg::CFG_RETRY_LIMIT:    retry_limit_r    <= cfg_data[7:0];
        rpt_pkg::CFG_RETRY_INTERVAL: retry_interval_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lowest-indexed free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  // Admission check for a send: room under the effective limit, and a known peer.
  assign eff_limit = ({27'd0, pending_limit_r} < 32'(SLOTS)) ?
                     {27'd0, pending_limit_r} : 32'(SLOTS);
  assign send_ok = ({28'd0, in_peer_index} < 32'(PEERS)) &&
                   ({{(32 - PW){1'b0}}, total_r} < eff_limit) && free_found;

  // Deadline from the current time; during a tick the time is already advanced.
  assign new_deadline = tick_now_r + {16'd0, retry_interval_r};

  // Checks on the entry returned by the memory.
  assign rd_valid = valid_r[rd_idx_r];
  assign dl_diff  = rd_slot.deadline - tick_now_r;
  assign expired  = (dl_diff == 32'd0) || dl_diff[31];
  assign ack_hit  = rd_valid && (rd_slot.seq == ack_seq_r) && (rd_slot.peer == peer_r);

  // Next state, memory control and results.
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    peer_nxt     = peer_r;
    ack_seq_nxt  = ack_seq_r;
    idx_nxt      = idx_r;
    iss_done_nxt = iss_done_r;
    rd_pend_nxt  = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    valid_nxt    = valid_r;
    total_nxt    = total_r;
    next_seq_nxt = next_seq_r;
    tick_now_nxt = tick_now_r;

    o_valid_nxt  = 1'b0;
    o_kind_nxt   = o_kind_r;
    o_seq_nxt    = o_seq_r;
    o_peer_nxt   = o_peer_r;
    o_tag_nxt    = o_tag_r;
    o_att_nxt    = o_att_r;
    o_last_nxt   = o_last_r;

    ram_we       = 1'b0;
    ram_waddr    = rd_idx_r;
    ram_wdata    = rd_slot;
    ram_re       = 1'b0;

    unique case (state_r)
      rpt_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt       = rpt_pkg::op_t'(in_op);
          peer_nxt     = in_peer_index;
          ack_seq_nxt  = in_ack_sequence;
          idx_nxt      = '0;
          iss_done_nxt = 1'b0;
          unique case (rpt_pkg::op_t'(in_op))
            rpt_pkg::OP_SEND: begin
              o_valid_nxt = 1'b1;
              o_peer_nxt  = in_peer_index;
              o_tag_nxt   = in_payload_tag;
              o_att_nxt   = 8'd0;
              o_last_nxt  = 1'b1;
              if (send_ok) begin
                // Record the message in the lowest free slot.
                ram_we             = 1'b1;
                ram_waddr          = free_idx;
                ram_wdata.seq      = next_seq_r;
                ram_wdata.peer     = in_peer_index;
                ram_wdata.tag      = in_payload_tag;
                ram_wdata.deadline = new_deadline;
                ram_wdata.attempts = 8'd0;
                valid_nxt[free_idx] = 1'b1;
                total_nxt    = total_r + PW'(1);
                next_seq_nxt = next_seq_r + 32'd1;
                o_kind_nxt   = rpt_pkg::KIND_SENT;
                o_seq_nxt    = next_seq_r;
              end else begin
                o_kind_nxt   = rpt_pkg::KIND_DROP_FULL;
                o_seq_nxt    = 32'd0;
              end
            end
            rpt_pkg::OP_ACK: begin
              state_nxt = rpt_pkg::ST_SCAN;
            end
            rpt_pkg::OP_TICK: begin
              tick_now_nxt = tick_now_r + 32'd1;
              state_nxt    = rpt_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      rpt_pkg::ST_SCAN: begin
        // Issue one slot read per cycle.
        if (!iss_done_r) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = idx_r;
          idx_nxt     = idx_r + AW'(1);
          if (idx_r == LAST_IDX) begin
            iss_done_nxt = 1'b1;
          end
        end
        // Handle the slot whose data arrived this cycle.
        if (rd_pend_r) begin
          if (op_r == rpt_pkg::OP_ACK) begin
            if (ack_hit) begin
              valid_nxt[rd_idx_r] = 1'b0;
              if (total_r != '0) begin
                total_nxt = total_r - PW'(1);
              end
              o_valid_nxt = 1'b1;
              o_kind_nxt  = rpt_pkg::KIND_ACK_MATCHED;
              o_seq_nxt   = ack_seq_r;
              o_peer_nxt  = peer_r;
              o_tag_nxt   = rd_slot.tag;
              o_att_nxt   = rd_slot.attempts;
              o_last_nxt  = 1'b1;
              rd_pend_nxt = 1'b0;
              state_nxt   = rpt_pkg::ST_IDLE;
            end else if (rd_idx_r == LAST_IDX) begin
              o_valid_nxt = 1'b1;
              o_kind_nxt  = rpt_pkg::KIND_ACK_IGNORED;
              o_seq_nxt   = ack_seq_r;
              o_peer_nxt  = peer_r;
              o_tag_nxt   = 16'd0;
              o_att_nxt   = 8'd0;
              o_last_nxt  = 1'b1;
              state_nxt   = rpt_pkg::ST_IDLE;
            end
          end else begin
            if (rd_valid && expired) begin
              o_valid_nxt = 1'b1;
              o_seq_nxt   = rd_slot.seq;
              o_peer_nxt  = rd_slot.peer;
              o_tag_nxt   = rd_slot.tag;
              o_last_nxt  = 1'b0;
              if (rd_slot.attempts >= retry_limit_r) begin
                // Out of retries: free the slot.
                valid_nxt[rd_idx_r] = 1'b0;
                if (total_r != '0) begin
                  total_nxt = total_r - PW'(1);
                end
                o_kind_nxt = rpt_pkg::KIND_DROP_RETRIES;
                o_att_nxt  = rd_slot.attempts;
              end else begin
                // Retransmit and write back the new deadline and count.
                ram_we             = 1'b1;
                ram_waddr          = rd_idx_r;
                ram_wdata.deadline = new_deadline;
                ram_wdata.attempts = rd_slot.attempts + 8'd1;
                o_kind_nxt = rpt_pkg::KIND_RETRANSMIT;
                o_att_nxt  = rd_slot.attempts + 8'd1;
              end
            end
            if (rd_idx_r == LAST_IDX) begin
              state_nxt = rpt_pkg::ST_DONE;
            end
          end
        end
      end

      rpt_pkg::ST_DONE: begin
        o_valid_nxt = 1'b1;
        o_kind_nxt  = rpt_pkg::KIND_TICK_DONE;
        o_seq_nxt   = 32'd0;
        o_peer_nxt  = 4'd0;
        o_tag_nxt   = 16'd0;
        o_att_nxt   = 8'd0;
        o_last_nxt  = 1'b1;
        state_nxt   = rpt_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = rpt_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_done_r <= 1'b0;
      rd_pend_r  <= 1'b0;
      valid_r    <= '0;
      total_r    <= '0;
      next_seq_r <= 32'd1;
      tick_now_r <= 32'd0;
      o_valid_r  <= 1'b0;
    end else begin
      iss_done_r <= iss_done_nxt;
      rd_pend_r  <= rd_pend_nxt;
      valid_r    <= valid_nxt;
      total_r    <= total_nxt;
      next_seq_r <= next_seq_nxt;
      tick_now_r <= tick_now_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    peer_r    <= peer_nxt;
    ack_seq_r <= ack_seq_nxt;
    idx_r     <= idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    o_kind_r  <= o_kind_nxt;
    o_seq_r   <= o_seq_nxt;
    o_peer_r  <= o_peer_nxt;
    o_tag_r   <= o_tag_nxt;
    o_att_r   <= o_att_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign busy              = (state_r != rpt_pkg::ST_IDLE);
  assign out_valid         = o_valid_r;
  assign out_kind          = o_kind_r;
  assign out_sequence_res  = o_seq_r;
  assign out_peer          = o_peer_r;
  assign out_tag           = o_tag_r;
  assign out_attempt_count = o_att_r;
  assign out_last          = o_last_r;

endmodule

`default_nettype wire
